FILE: rtl/tsq_pkg.sv
package tsq_pkg;

  // field types
  typedef logic [11:0] sample_t;
  typedef logic [12:0] pres_t;
  typedef logic [31:0] ms_t;
  typedef logic [7:0]  interval_t;

  // item kinds
  typedef enum logic {
    OP_PEN   = 1'b0,
    OP_FRAME = 1'b1
  } op_e;

  // orientation codes
  typedef enum logic [1:0] {
    ROT_FLIP_B    = 2'd0,
    ROT_DIRECT    = 2'd1,
    ROT_FLIP_A    = 2'd2,
    ROT_FLIP_BOTH = 2'd3
  } rot_e;

  // register map, word index
  typedef enum logic [2:0] {
    REG_ROTATION = 3'd0,
    REG_PRESS    = 3'd1,
    REG_RELEASE  = 3'd2,
    REG_INTERVAL = 3'd3,
    REG_IRQ_USED = 3'd4
  } reg_e;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam sample_t   AXIS_MAX        = 12'd4095;
  localparam pres_t     PRESSURE_OFFSET = 13'd4095;
  localparam pres_t     PRESS_RST       = 13'd400;
  localparam pres_t     RELEASE_RST     = 13'd75;
  localparam interval_t INTERVAL_RST    = 8'd3;

  // captured input transaction
  typedef struct packed {
    op_e     opcode;
    ms_t     now_ms;
    sample_t z1_sample;
    sample_t z2_sample;
    sample_t first_a;
    sample_t first_b;
    sample_t second_a;
    sample_t second_b;
    sample_t third_a;
    sample_t third_b;
  } in_item_t;

  // result transaction
  typedef struct packed {
    sample_t x_coord;
    sample_t y_coord;
    pres_t   pressure;
    logic    is_touched;
    logic    awake;
    logic    frame_used;
    logic    rate_wait;
  } out_item_t;

  // absolute difference of two samples
  function automatic sample_t sample_gap(sample_t p, sample_t q);
    return (p > q) ? (p - q) : (q - p);
  endfunction

  // mean of the closest two of three samples, earlier pairs win ties
  function automatic sample_t closest_mean(sample_t p, sample_t q, sample_t r);
    sample_t    dpq;
    sample_t    dpr;
    sample_t    dqr;
    logic [12:0] sum;
    dpq = sample_gap(p, q);
    dpr = sample_gap(p, r);
    dqr = sample_gap(q, r);
    if (dpq <= dpr && dpq <= dqr) begin
      sum = {1'b0, p} + {1'b0, q};
    end else if (dpr <= dpq && dpr <= dqr) begin
      sum = {1'b0, p} + {1'b0, r};
    end else begin
      sum = {1'b0, q} + {1'b0, r};
    end
    return sum[12:1];
  endfunction

endpackage

FILE: rtl/tsq_if.sv
// input channel
interface tsq_in_if;
  logic                 valid;
  logic                 ready;
  tsq_pkg::op_e         opcode;
  tsq_pkg::ms_t         now_ms;
  tsq_pkg::sample_t     z1_sample;
  tsq_pkg::sample_t     z2_sample;
  tsq_pkg::sample_t     first_a;
  tsq_pkg::sample_t     first_b;
  tsq_pkg::sample_t     second_a;
  tsq_pkg::sample_t     second_b;
  tsq_pkg::sample_t     third_a;
  tsq_pkg::sample_t     third_b;

  modport source (
    output valid, opcode, now_ms, z1_sample, z2_sample,
    output first_a, first_b, second_a, second_b, third_a, third_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, z1_sample, z2_sample,
    input  first_a, first_b, second_a, second_b, third_a, third_b,
    output ready
  );
endinterface

// result channel
interface tsq_out_if;
  logic             valid;
  logic             ready;
  tsq_pkg::sample_t x_coord;
  tsq_pkg::sample_t y_coord;
  tsq_pkg::pres_t   pressure;
  logic             is_touched;
  logic             awake;
  logic             frame_used;
  logic             rate_wait;

  modport source (
    output valid, x_coord, y_coord, pressure, is_touched, awake, frame_used, rate_wait,
    input  ready
  );
  modport sink (
    input  valid, x_coord, y_coord, pressure, is_touched, awake, frame_used, rate_wait,
    output ready
  );
endinterface

FILE: rtl/tsq_axis_pick.sv
module tsq_axis_pick (
  input  tsq_pkg::in_item_t item,
  input  tsq_pkg::rot_e     rotation_mode,
  output tsq_pkg::sample_t  x_coord,
  output tsq_pkg::sample_t  y_coord
);

  tsq_pkg::sample_t mean_a;
  tsq_pkg::sample_t mean_b;

  // best two of three on each axis group
  assign mean_a = tsq_pkg::closest_mean(item.first_a, item.second_a, item.third_a);
  assign mean_b = tsq_pkg::closest_mean(item.first_b, item.second_b, item.third_b);

  // orientation mapping
  always_comb begin
    case (rotation_mode)
      tsq_pkg::ROT_FLIP_B: begin
        x_coord = tsq_pkg::AXIS_MAX - mean_b;
        y_coord = mean_a;
      end
      tsq_pkg::ROT_DIRECT: begin
        x_coord = mean_a;
        y_coord = mean_b;
      end
      tsq_pkg::ROT_FLIP_A: begin
        x_coord = mean_b;
        y_coord = tsq_pkg::AXIS_MAX - mean_a;
      end
      default: begin
        x_coord = tsq_pkg::AXIS_MAX - mean_a;
        y_coord = tsq_pkg::AXIS_MAX - mean_b;
      end
    endcase
  end

endmodule

FILE: rtl/touch_sample_qualifier.sv
// a transaction is captured in the input register on acceptance, and its result is
// registered into the result register when the input stage advances
// throughput: one transaction per cycle while the result channel does not stall, with the
// state update between the input register and the result register
// reset: synchronous, wake flag set, time stamp, coordinates and pressure cleared,
// registers back to their default values, both pipeline stages empty
module touch_sample_qualifier (
  input  logic                            clk,
  input  logic                            rst,
  tsq_in_if.sink                          in_ch,
  tsq_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsq_pkg::PADDR_W-1:0]     paddr,
  input  logic [tsq_pkg::PDATA_W-1:0]     pwdata,
  output logic [tsq_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  // configuration registers
  tsq_pkg::rot_e      rotation_mode;
  tsq_pkg::pres_t     press_threshold;
  tsq_pkg::pres_t     release_threshold;
  tsq_pkg::interval_t min_interval_ms;
  logic               irq_pin_used;

  // qualifier state
  logic               wake_flag;
  tsq_pkg::ms_t       last_good_time;
  tsq_pkg::sample_t   stored_x;
  tsq_pkg::sample_t   stored_y;
  tsq_pkg::pres_t     stored_pressure;

  logic               wake_flag_next;
  tsq_pkg::ms_t       last_good_time_next;
  tsq_pkg::sample_t   stored_x_next;
  tsq_pkg::sample_t   stored_y_next;
  tsq_pkg::pres_t     stored_pressure_next;

  // pipeline registers
  logic               s1_valid;
  tsq_pkg::in_item_t  s1_item;
  logic               out_valid;
  tsq_pkg::out_item_t out_item;

  logic               s1_adv;
  logic               cfg_write;
  tsq_pkg::reg_e      cfg_sel;
  tsq_pkg::ms_t       elapsed;
  tsq_pkg::pres_t     z_val;
  tsq_pkg::sample_t   pick_x;
  tsq_pkg::sample_t   pick_y;
  logic               used;
  logic               wait_flag;

  // register access
  assign pready    = 1'b1;
  assign cfg_sel   = tsq_pkg::reg_e'(paddr[tsq_pkg::PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode     <= tsq_pkg::ROT_FLIP_B;
      press_threshold   <= tsq_pkg::PRESS_RST;
      release_threshold <= tsq_pkg::RELEASE_RST;
      min_interval_ms   <= tsq_pkg::INTERVAL_RST;
      irq_pin_used      <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        tsq_pkg::REG_ROTATION: rotation_mode     <= tsq_pkg::rot_e'(pwdata[1:0]);
        tsq_pkg::REG_PRESS:    press_threshold   <= pwdata[12:0];
        tsq_pkg::REG_RELEASE:  release_threshold <= pwdata[12:0];
        tsq_pkg::REG_INTERVAL: min_interval_ms   <= pwdata[7:0];
        tsq_pkg::REG_IRQ_USED: irq_pin_used      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_sel)
      tsq_pkg::REG_ROTATION: prdata = {30'd0, rotation_mode};
      tsq_pkg::REG_PRESS:    prdata = {19'd0, press_threshold};
      tsq_pkg::REG_RELEASE:  prdata = {19'd0, release_threshold};
      tsq_pkg::REG_INTERVAL: prdata = {24'd0, min_interval_ms};
      tsq_pkg::REG_IRQ_USED: prdata = {31'd0, irq_pin_used};
      default:               prdata = '0;
    endcase
  end

  // handshake: input stage moves on when the result register is free or draining
  assign s1_adv       = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item <= '{opcode:    in_ch.opcode,
                   now_ms:    in_ch.now_ms,
                   z1_sample: in_ch.z1_sample,
                   z2_sample: in_ch.z2_sample,
                   first_a:   in_ch.first_a,
                   first_b:   in_ch.first_b,
                   second_a:  in_ch.second_a,
                   second_b:  in_ch.second_b,
                   third_a:   in_ch.third_a,
                   third_b:   in_ch.third_b};
    end
  end

  // axis filter and orientation
  tsq_axis_pick u_axis_pick (
    .item          (s1_item),
    .rotation_mode (rotation_mode),
    .x_coord       (pick_x),
    .y_coord       (pick_y)
  );

  // pressure never goes negative with the offset added
  assign z_val   = {1'b0, s1_item.z1_sample} + tsq_pkg::PRESSURE_OFFSET
                   - {1'b0, s1_item.z2_sample};
  assign elapsed = s1_item.now_ms - last_good_time;

  // gate and state update
  always_comb begin
    wake_flag_next       = wake_flag;
    last_good_time_next  = last_good_time;
    stored_x_next        = stored_x;
    stored_y_next        = stored_y;
    stored_pressure_next = stored_pressure;
    used                 = 1'b0;
    wait_flag            = 1'b0;
    if (s1_adv) begin
      if (s1_item.opcode == tsq_pkg::OP_PEN) begin
        wake_flag_next = 1'b1;
      end else if (wake_flag) begin
        if (elapsed < {24'd0, min_interval_ms}) begin
          wait_flag = 1'b1;
        end else begin
          used = 1'b1;
          if (z_val < press_threshold) begin
            stored_pressure_next = '0;
            if (z_val < release_threshold && irq_pin_used) begin
              wake_flag_next = 1'b0;
            end
          end else begin
            stored_pressure_next = z_val;
            last_good_time_next  = s1_item.now_ms;
            stored_x_next        = pick_x;
            stored_y_next        = pick_y;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_flag       <= 1'b1;
      last_good_time  <= '0;
      stored_x        <= '0;
      stored_y        <= '0;
      stored_pressure <= '0;
    end else begin
      wake_flag       <= wake_flag_next;
      last_good_time  <= last_good_time_next;
      stored_x        <= stored_x_next;
      stored_y        <= stored_y_next;
      stored_pressure <= stored_pressure_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= '{x_coord:    stored_x_next,
                    y_coord:    stored_y_next,
                    pressure:   stored_pressure_next,
                    is_touched: (stored_pressure_next >= press_threshold),
                    awake:      wake_flag_next,
                    frame_used: used,
                    rate_wait:  wait_flag};
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.x_coord    = out_item.x_coord;
  assign out_ch.y_coord    = out_item.y_coord;
  assign out_ch.pressure   = out_item.pressure;
  assign out_ch.is_touched = out_item.is_touched;
  assign out_ch.awake      = out_item.awake;
  assign out_ch.frame_used = out_item.frame_used;
  assign out_ch.rate_wait  = out_item.rate_wait;

`ifndef NO_ASSERTIONS
  // a frame is either used or held back, never both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.frame_used && out_item.rate_wait))
    else $error("frame both used and rate limited");

  // a rate limited frame only happens while awake
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.rate_wait) |-> out_item.awake)
    else $error("rate wait reported while asleep");

  // a used frame is either a touch or clears the pressure
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_used) |-> (out_item.is_touched || out_item.pressure == '0))
    else $error("used frame left stale pressure");

  // pen interrupt always wakes the qualifier
  assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_item.opcode == tsq_pkg::OP_PEN) |=> wake_flag)
    else $error("pen interrupt did not set wake flag");

  // the good read time stamp only moves when a transaction is processed
  assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(last_good_time))
    else $error("time stamp changed without a transaction");
`endif

endmodule
